// ===== rtl/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types, widths and codes for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int BASE_W     = 32;
  localparam int LIMIT_W    = 17;
  localparam int REQ_W      = 16;
  localparam int NEED_W     = 17;
  localparam int ADDR_W     = 32;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int HDR_BYTES  = 8;

  localparam int DEF_MAX_BLOCKS = 64;
  localparam int DEF_HEAP_BYTES = 65536;

  localparam logic [LIMIT_W-1:0] HEAP_LIMIT_RESET = LIMIT_W'(65536);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_SPACE    = 2'd1,
    ST_BAD_ADDRESS = 2'd2
  } status_e;

  typedef enum logic {
    CFG_HEAP_BASE  = 1'b0,
    CFG_HEAP_LIMIT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit_hit;
    logic commit_miss;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    logic miss;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/ffba_req_if.sv =====
// ----------------------------------------------------------------------------
// ffba_req_if
// Request channel: allocate or free item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ffba_req_if import ffba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [REQ_W-1:0]  request_bytes;
  logic [ADDR_W-1:0] release_address;

  modport source (output valid, opcode, request_bytes, release_address, input ready);
  modport sink   (input valid, opcode, request_bytes, release_address, output ready);
endinterface

// ===== rtl/ffba_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ffba_rsp_if
// Response channel: user address and status with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ffba_rsp_if import ffba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] user_address;
  logic [1:0]        status;

  modport source (output valid, user_address, status, input ready);
  modport sink   (input valid, user_address, status, output ready);
endinterface

// ===== rtl/ffba_ram.sv =====
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ffba_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ffba_cfg_regs
// APB-style register file holding heap base and heap limit.
// ----------------------------------------------------------------------------
module ffba_cfg_regs import ffba_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [BASE_W-1:0]     heap_base_o,
  output logic [LIMIT_W-1:0]    heap_limit_o
);

  logic [BASE_W-1:0]  heap_base_q;
  logic [LIMIT_W-1:0] heap_limit_q;
  logic               wr_en;
  cfg_reg_e           reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  // registers sit on 4-byte boundaries, low address bits are ignored
  assign reg_sel = cfg_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q  <= '0;
      heap_limit_q <= HEAP_LIMIT_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        CFG_HEAP_BASE:  heap_base_q  <= pwdata[BASE_W-1:0];
        CFG_HEAP_LIMIT: heap_limit_q <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      CFG_HEAP_BASE:  prdata = APB_DATA_W'(heap_base_q);
      CFG_HEAP_LIMIT: prdata = APB_DATA_W'(heap_limit_q);
      default:        prdata = '0;
    endcase
  end

  assign heap_base_o  = heap_base_q;
  assign heap_limit_o = heap_limit_q;

endmodule

// ===== rtl/ffba_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer: accept, scan the block table, commit, hand over the result.
// ----------------------------------------------------------------------------
module ffba_ctrl import ffba_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t stat_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.hit) begin
          cmd_o.commit_hit = 1'b1;
          state_d          = S_OUT;
        end else if (stat_i.miss) begin
          cmd_o.commit_miss = 1'b1;
          state_d           = S_OUT;
        end
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/ffba_dp.sv =====
// ----------------------------------------------------------------------------
// ffba_dp
// Datapath: block table memory, scan pipeline, append logic, result register.
// ----------------------------------------------------------------------------
module ffba_dp import ffba_pkg::*; #(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
  parameter int HEAP_BYTES = DEF_HEAP_BYTES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_status_t         stat_o,
  input  logic               opcode_i,
  input  logic [REQ_W-1:0]   request_bytes_i,
  input  logic [ADDR_W-1:0]  release_address_i,
  input  logic [BASE_W-1:0]  heap_base_i,
  input  logic [LIMIT_W-1:0] heap_limit_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [ADDR_W-1:0]  user_address_o,
  output logic [1:0]         out_status_o
);

  localparam int AW      = $clog2(MAX_BLOCKS);
  localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
  localparam int START_W = $clog2(HEAP_BYTES);
  localparam int END_W   = $clog2(HEAP_BYTES + 1);
  localparam int LIM_W   = (END_W > LIMIT_W) ? END_W : LIMIT_W;
  localparam int ENT_W   = 1 + NEED_W + START_W;

  localparam logic [LIM_W-1:0]  HEAP_LIM = LIM_W'(HEAP_BYTES);
  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(MAX_BLOCKS);
  localparam logic [ADDR_W-1:0] HDR      = ADDR_W'(HDR_BYTES);

  // control state
  logic [CNT_W-1:0] count_q, count_d;
  logic [END_W-1:0] heap_end_q, heap_end_d;
  logic [CNT_W-1:0] scan_idx_q, scan_idx_d;
  logic             chk_vld_q, chk_vld_d;
  logic [AW-1:0]    chk_idx_q, chk_idx_d;
  logic             out_vld_q, out_vld_d;

  // payload
  opcode_e           op_q;
  logic [NEED_W-1:0] need_q;
  logic [ADDR_W-1:0] off_q;
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;
  status_e           res_stat_q, res_stat_d;
  logic [ADDR_W-1:0] out_addr_q;
  status_e           out_stat_q;

  // table memory
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;

  logic               ent_free;
  logic [NEED_W-1:0]  ent_size;
  logic [START_W-1:0] ent_start;
  logic               match;
  logic               issue;
  logic [LIM_W-1:0]   lim;
  logic [LIM_W:0]     end_sum;
  logic               no_space;

  ffba_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (scan_idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign ent_free  = ram_rdata[ENT_W-1];
  assign ent_size  = ram_rdata[START_W +: NEED_W];
  assign ent_start = ram_rdata[START_W-1:0];

  always_comb begin
    if (op_q == OP_ALLOC) begin
      match = ent_free && (ent_size >= need_q);
    end else begin
      match = (ADDR_W'(ent_start) == off_q);
    end
  end

  assign issue  = cmd_i.scan && (scan_idx_q < count_q);
  assign ram_re = issue;

  assign stat_o.hit      = chk_vld_q && match;
  assign stat_o.miss     = !chk_vld_q && (scan_idx_q >= count_q);
  assign stat_o.out_free = !out_vld_q || out_ready_i;

  // usable limit and append check
  assign lim      = (LIM_W'(heap_limit_i) > HEAP_LIM) ? HEAP_LIM : LIM_W'(heap_limit_i);
  assign end_sum  = (LIM_W + 1)'(heap_end_q) + (LIM_W + 1)'(need_q);
  assign no_space = (count_q == CNT_FULL) || (end_sum > {1'b0, lim});

  always_comb begin
    count_d    = count_q;
    heap_end_d = heap_end_q;
    scan_idx_d = scan_idx_q;
    chk_vld_d  = chk_vld_q;
    chk_idx_d  = chk_idx_q;
    out_vld_d  = out_vld_q;
    res_addr_d = res_addr_q;
    res_stat_d = res_stat_q;
    ram_we     = 1'b0;
    ram_waddr  = chk_idx_q;
    ram_wdata  = ram_rdata;

    if (cmd_i.start) begin
      scan_idx_d = '0;
      chk_vld_d  = 1'b0;
    end

    if (cmd_i.scan) begin
      chk_vld_d = issue;
      chk_idx_d = scan_idx_q[AW-1:0];
      if (issue) begin
        scan_idx_d = scan_idx_q + CNT_W'(1);
      end
    end

    if (cmd_i.commit_hit) begin
      ram_we     = 1'b1;
      ram_waddr  = chk_idx_q;
      res_stat_d = ST_OK;
      if (op_q == OP_ALLOC) begin
        ram_wdata  = {1'b0, ent_size, ent_start};
        res_addr_d = heap_base_i + ADDR_W'(ent_start) + HDR;
      end else begin
        ram_wdata  = {1'b1, ent_size, ent_start};
        res_addr_d = '0;
      end
    end

    if (cmd_i.commit_miss) begin
      res_addr_d = '0;
      if (op_q == OP_FREE) begin
        res_stat_d = ST_BAD_ADDRESS;
      end else if (no_space) begin
        res_stat_d = ST_NO_SPACE;
      end else begin
        // append a new block at the heap end
        ram_we     = 1'b1;
        ram_waddr  = count_q[AW-1:0];
        ram_wdata  = {1'b0, need_q, heap_end_q[START_W-1:0]};
        count_d    = count_q + CNT_W'(1);
        heap_end_d = end_sum[END_W-1:0];
        res_stat_d = ST_OK;
        res_addr_d = heap_base_i + ADDR_W'(heap_end_q) + HDR;
      end
    end

    if (cmd_i.load_out) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      heap_end_q <= '0;
      scan_idx_q <= '0;
      chk_vld_q  <= 1'b0;
      chk_idx_q  <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      count_q    <= count_d;
      heap_end_q <= heap_end_d;
      scan_idx_q <= scan_idx_d;
      chk_vld_q  <= chk_vld_d;
      chk_idx_q  <= chk_idx_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q   <= opcode_e'(opcode_i);
      need_q <= NEED_W'(request_bytes_i) + NEED_W'(HDR_BYTES);
      off_q  <= release_address_i - HDR - heap_base_i;
    end
    res_addr_q <= res_addr_d;
    res_stat_q <= res_stat_d;
    if (cmd_i.load_out) begin
      out_addr_q <= res_addr_q;
      out_stat_q <= res_stat_q;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign user_address_o = out_addr_q;
  assign out_status_o   = out_stat_q;

endmodule

// ===== rtl/first_fit_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit
// First-fit heap allocator over a block table, no splitting, no coalescing.
// ----------------------------------------------------------------------------
// usage
//   req: one allocate or free item per handshake (valid and ready high)
//   rsp: one result item per request, user address and status
//   apb: heap_base at 0x0, heap_limit at 0x4, write only while idle
// timing
//   the scan reads one table entry per cycle from a memory with registered
//   read and stops at the first matching entry; with n blocks in the table
//   and no match it checks all n entries, then appends a new block or
//   reports no space or a bad address; the result passes a result register
//   and then the output register; the next item is taken in the cycle after
//   the result is loaded
//   one item is in work at a time; a new request is taken while the last
//   result still waits in the output register
// reset
//   table empty, heap end zero, heap_base 0, heap_limit 65536; no clearing
//   pass, entries beyond the block count are never read
// stall
//   a stalled result holds the output register; the next item finishes its
//   scan and then waits until the register is taken
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit import ffba_pkg::*; #(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
  parameter int HEAP_BYTES = DEF_HEAP_BYTES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ffba_req_if.sink              req,
  ffba_rsp_if.source            rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [BASE_W-1:0]  heap_base;
  logic [LIMIT_W-1:0] heap_limit;
  dp_cmd_t            cmd;
  dp_status_t         stat;

  ffba_cfg_regs u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .heap_base_o  (heap_base),
    .heap_limit_o (heap_limit)
  );

  ffba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ffba_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .HEAP_BYTES (HEAP_BYTES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .opcode_i          (req.opcode),
    .request_bytes_i   (req.request_bytes),
    .release_address_i (req.release_address),
    .heap_base_i       (heap_base),
    .heap_limit_i      (heap_limit),
    .out_ready_i       (rsp.ready),
    .out_valid_o       (rsp.valid),
    .user_address_o    (rsp.user_address),
    .out_status_o      (rsp.status)
  );

endmodule

// ===== sim/ffba_heap_checker.sv =====
// ----------------------------------------------------------------------------
// ffba_heap_checker
// Watches the request, response and register channels of the allocator,
// keeps its own copy of the block table and flags every result that differs.
// ----------------------------------------------------------------------------
module ffba_heap_checker import ffba_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ffba_req_if                   req,
  ffba_rsp_if                   rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int unsigned           mismatch_count,
  output int unsigned           outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxBlocks = DEF_MAX_BLOCKS;
  localparam int HeapBytes = DEF_HEAP_BYTES;

  typedef struct packed {
    logic [ADDR_W-1:0] user_address;
    status_e           status;
  } heap_rsp_t;

  logic [NEED_W-1:0]  blk_start [MaxBlocks];
  logic [NEED_W-1:0]  blk_size  [MaxBlocks];
  logic               blk_free  [MaxBlocks];
  int unsigned        blk_count;
  logic [LIMIT_W-1:0] heap_end;
  logic [BASE_W-1:0]  heap_base;
  logic [LIMIT_W-1:0] heap_limit;

  heap_rsp_t   awaited_rsp [$];
  heap_rsp_t   oldest;
  int unsigned errs;

  // applies one allocate or free to the table copy and returns its result
  function automatic heap_rsp_t apply_heap_op(opcode_e op, logic [REQ_W-1:0] nbytes,
                                              logic [ADDR_W-1:0] rel);
    heap_rsp_t   r;
    logic [31:0] need;
    logic [31:0] lim;
    logic [31:0] off;
    bit          found;
    r.user_address = '0;
    r.status       = ST_OK;
    found          = 1'b0;
    if (op == OP_ALLOC) begin
      need = 32'(nbytes) + 32'(HDR_BYTES);
      for (int i = 0; i < blk_count; i++) begin
        if (blk_free[i] && 32'(blk_size[i]) >= need) begin
          blk_free[i]    = 1'b0;
          r.user_address = heap_base + 32'(blk_start[i]) + 32'(HDR_BYTES);
          found          = 1'b1;
          break;
        end
      end
      if (!found) begin
        lim = (32'(heap_limit) > 32'(HeapBytes)) ? 32'(HeapBytes) : 32'(heap_limit);
        if (blk_count >= MaxBlocks || 32'(heap_end) > lim || need > lim - 32'(heap_end)) begin
          r.status = ST_NO_SPACE;
        end else begin
          blk_start[blk_count] = NEED_W'(heap_end);
          blk_size[blk_count]  = NEED_W'(need);
          blk_free[blk_count]  = 1'b0;
          blk_count++;
          r.user_address = heap_base + 32'(heap_end) + 32'(HDR_BYTES);
          heap_end       = LIMIT_W'(32'(heap_end) + need);
        end
      end
    end else begin
      off = rel - 32'(HDR_BYTES) - heap_base;
      for (int i = 0; i < blk_count; i++) begin
        if (32'(blk_start[i]) == off) begin
          blk_free[i] = 1'b1;
          found       = 1'b1;
          break;
        end
      end
      if (!found) r.status = ST_BAD_ADDRESS;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_count  = 0;
      heap_end   = '0;
      heap_base  = '0;
      heap_limit = HEAP_LIMIT_RESET;
      errs       = 0;
      awaited_rsp.delete();
      mismatch_count <= 0;
      outstanding    <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_e'(paddr[2]))
          CFG_HEAP_BASE:  heap_base  = pwdata[BASE_W-1:0];
          CFG_HEAP_LIMIT: heap_limit = pwdata[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        awaited_rsp.push_back(apply_heap_op(opcode_e'(req.opcode), req.request_bytes,
                                            req.release_address));
      end
      if (rsp.valid && rsp.ready) begin
        if (awaited_rsp.size() == 0) begin
          if (errs < 10) begin
            $display("%0t: result with nothing awaited: addr %h status %0d",
                     $realtime, rsp.user_address, rsp.status);
          end
          errs++;
        end else begin
          oldest = awaited_rsp.pop_front();
          if (rsp.user_address !== oldest.user_address || rsp.status !== oldest.status) begin
            if (errs < 10) begin
              $display("%0t: mismatch: expected addr %h status %s, got addr %h status %0d",
                       $realtime, oldest.user_address, oldest.status.name(),
                       rsp.user_address, rsp.status);
            end
            errs++;
          end
        end
      end
      mismatch_count <= errs;
      outstanding    <= awaited_rsp.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives allocate and free items and register writes into the first-fit
// allocator under several idle and stall patterns; the heap checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench import ffba_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PhaseItems = 283;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned gap_pct;
  int unsigned stall_pct;

  logic [BASE_W-1:0] cur_base;
  logic [ADDR_W-1:0] granted_offsets [$];

  ffba_req_if req_ch ();
  ffba_rsp_if rsp_ch ();

  first_fit_block_allocator_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ffba_heap_checker i_heap_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always #2 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // remember handed-out user addresses as offsets so frees can target live blocks
  always @(posedge clk_i) begin
    if (rsp_ch.valid && rsp_ch.ready && rsp_ch.status == ST_OK &&
        rsp_ch.user_address != '0) begin
      granted_offsets.push_back(rsp_ch.user_address - cur_base);
      if (granted_offsets.size() > 128) void'(granted_offsets.pop_front());
    end
  end

  task automatic send_item(opcode_e op, logic [REQ_W-1:0] nbytes, logic [ADDR_W-1:0] rel);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      req_ch.valid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < gap_pct);
    end
    req_ch.valid           <= 1'b1;
    req_ch.opcode          <= op;
    req_ch.request_bytes   <= nbytes;
    req_ch.release_address <= rel;
    do @(posedge clk_i); while (!req_ch.ready);
    @(negedge clk_i);
  endtask

  // hold the sender off until every awaited result has been taken
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
  endtask

  task automatic cfg_write(cfg_reg_e idx, logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * idx);
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == CFG_HEAP_BASE) cur_base = value;
  endtask

  task automatic random_item();
    int unsigned       pick;
    int unsigned       k;
    logic [REQ_W-1:0]  nbytes;
    logic [ADDR_W-1:0] rel;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      case ($urandom_range(0, 19))
        0:       nbytes = REQ_W'($urandom);
        1, 2, 3: nbytes = REQ_W'($urandom_range(0, 4095));
        default: nbytes = REQ_W'($urandom_range(0, 255));
      endcase
      send_item(OP_ALLOC, nbytes, $urandom);
    end else if (pick < 94 && granted_offsets.size() != 0) begin
      k   = $urandom_range(0, granted_offsets.size() - 1);
      rel = cur_base + granted_offsets[k];
      // near misses around a live address
      if (pick >= 88) rel = rel + $urandom_range(0, 16) - 8;
      send_item(OP_FREE, REQ_W'($urandom), rel);
    end else begin
      send_item(OP_FREE, REQ_W'($urandom), $urandom);
    end
  endtask

  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    req_ch.valid           = 1'b0;
    req_ch.opcode          = OP_ALLOC;
    req_ch.request_bytes   = '0;
    req_ch.release_address = '0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    gap_pct                = 0;
    stall_pct              = 0;
    cur_base               = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: fresh heap, oversize request, reuse, double free, bad addresses
    send_item(OP_ALLOC, 16'd0, '0);
    send_item(OP_ALLOC, 16'hFFFF, '0);
    send_item(OP_ALLOC, 16'd100, '0);
    send_item(OP_FREE, 16'd0, 32'd16);
    send_item(OP_FREE, 16'hFFFF, 32'd16);
    send_item(OP_FREE, 16'd0, 32'd0);
    send_item(OP_FREE, 16'd0, 32'hFFFF_FFFF);
    send_item(OP_ALLOC, 16'd50, '0);
    send_item(OP_ALLOC, 16'd200, 32'hFFFF_FFFF);

    // base near the top so addresses wrap
    settle();
    cfg_write(CFG_HEAP_BASE, 32'hFFFF_FFFF);
    send_item(OP_ALLOC, 16'd0, '0);
    send_item(OP_FREE, 16'd0, 32'hFFFF_FFFF + 32'd8);
    send_item(OP_ALLOC, 16'd0, '0);

    // limit below the heap end: appends fail, free blocks still reused
    settle();
    cfg_write(CFG_HEAP_LIMIT, 32'd64);
    send_item(OP_ALLOC, 16'd0, '0);
    send_item(OP_FREE, 16'd0, 32'hFFFF_FFFF + 32'd124);
    send_item(OP_ALLOC, 16'd150, '0);
    settle();
    cfg_write(CFG_HEAP_LIMIT, 32'd8);
    send_item(OP_ALLOC, 16'd0, '0);
    settle();
    cfg_write(CFG_HEAP_LIMIT, 32'd5);
    send_item(OP_ALLOC, 16'd0, '0);
    settle();
    cfg_write(CFG_HEAP_BASE, 32'd0);
    cfg_write(CFG_HEAP_LIMIT, 32'h1_0000);
    send_item(OP_FREE, 16'd0, 32'd16);
    send_item(OP_FREE, 16'd0, 32'd12);

    for (int phase = 0; phase < 4; phase++) begin
      settle();
      case (phase)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
          cfg_write(CFG_HEAP_BASE, $urandom);
        end
        1: begin
          gap_pct   = 51;
          stall_pct = 0;
          cfg_write(CFG_HEAP_BASE, 32'hFFFF_FF00);
          cfg_write(CFG_HEAP_LIMIT, $urandom_range(8, 65536));
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 51;
          cfg_write(CFG_HEAP_BASE, 32'd0);
          cfg_write(CFG_HEAP_LIMIT, $urandom_range(4096, 65536));
        end
        default: begin
          gap_pct   = 35;
          stall_pct = 35;
          cfg_write(CFG_HEAP_BASE, $urandom);
          cfg_write(CFG_HEAP_LIMIT, 32'h1_0000);
        end
      endcase
      repeat (PhaseItems) random_item();
    end

    settle();
    repeat (80) @(negedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ffba_pkg.sv
rtl/ffba_req_if.sv
rtl/ffba_rsp_if.sv
rtl/ffba_ram.sv
rtl/ffba_cfg_regs.sv
rtl/ffba_ctrl.sv
rtl/ffba_dp.sv
rtl/first_fit_block_allocator_unit.sv
sim/ffba_heap_checker.sv
sim/testbench.sv
